// ----- sv/cqfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cqfs_pkg
// Shared types and constants for the command queue frame sender.
// ----------------------------------------------------------------------------
package cqfs_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_CMD_BYTES = 4;
  localparam int IN_BYTES      = 4;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_CMD_BYTES + 1);
  localparam int CLEN_W = 4;
  localparam int DEPTH_W  = 5;
  localparam int STATUS_W = 3;

  // Frame layout: sync bytes, length byte, data bytes, checksum
  localparam int SYNC_COUNT = 3;
  localparam int LEN_STEP   = SYNC_COUNT;
  localparam int DATA_STEP0 = SYNC_COUNT + 1;
  localparam int STEP_W     = $clog2(DATA_STEP0 + MAX_CMD_BYTES + 1);

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  // Item kinds
  localparam logic KIND_ENQ  = 1'b0;
  localparam logic KIND_SEND = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_FULL     = 3'd2,
    ST_FRAME    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FRAME = 1'b1
  } state_e;

  // One queue entry
  typedef struct packed {
    logic [LEN_W-1:0]              len;
    logic [MAX_CMD_BYTES-1:0][7:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/cqfs_ram.sv -----
// ----------------------------------------------------------------------------
// cqfs_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module cqfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/command_queue_frame_sender_top.sv -----
// ----------------------------------------------------------------------------
// command_queue_frame_sender_top
// Ring queue of short commands with a sync/length/checksum frame transmitter.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start_i && !busy_o        kind_i, cmd_len_i, cmd_byte0_i..3_i
// result    out        result_valid_o (1 cycle)  status_o, frame_byte_o, last_o, depth_o
//
// Enqueue, bad-length, full and empty commands give one result the cycle after
// the transfer; a new command may follow at once.
// A send of a queued command gives 5 + length frame bytes, one per cycle, and
// holds busy_o until the last byte is registered; the framer reads one entry
// from the queue RAM per send.
// Reset clears pointers and occupancy at once; the queue RAM needs no clearing.
// The receiver cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module command_queue_frame_sender_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [cqfs_pkg::CLEN_W-1:0]   cmd_len_i,
  input  logic [7:0]                    cmd_byte0_i,
  input  logic [7:0]                    cmd_byte1_i,
  input  logic [7:0]                    cmd_byte2_i,
  input  logic [7:0]                    cmd_byte3_i,
  output logic                          result_valid_o,
  output logic [cqfs_pkg::STATUS_W-1:0] status_o,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_o,
  output logic [cqfs_pkg::DEPTH_W-1:0]  depth_o
);

  import cqfs_pkg::*;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [7:0]          sum_q, sum_d;
  logic                valid_q, valid_d;
  status_e             status_q, status_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;

  logic                accept;
  logic                len_ok;
  logic                full;
  logic                empty;
  logic                wr_en;
  logic                rd_en;
  entry_t              wr_entry;
  entry_t              rd_entry;
  logic [ENTRY_W-1:0]  rd_raw;
  logic [STEP_W-1:0]   sum_step;
  logic [7:0]          data_byte;
  logic [IN_BYTES-1:0][7:0] in_bytes;

  // Command transfer and queue conditions
  assign accept = start_i && !busy_o;
  assign len_ok = (cmd_len_i != '0) && (cmd_len_i <= CLEN_W'(MAX_CMD_BYTES));
  assign full   = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign empty  = (occ_q == '0);
  assign wr_en  = accept && (kind_i == KIND_ENQ) && len_ok && !full;
  assign rd_en  = accept && (kind_i == KIND_SEND) && !empty;

  // Pack the entry, zero-filling bytes past the input fields
  assign in_bytes = {cmd_byte3_i, cmd_byte2_i, cmd_byte1_i, cmd_byte0_i};
  always_comb begin
    wr_entry.len = LEN_W'(cmd_len_i);
    for (int b = 0; b < MAX_CMD_BYTES; b++) begin
      wr_entry.data[b] = (b < IN_BYTES) ? in_bytes[b] : 8'h00;
    end
  end

  // Queue store; the read entry holds while the frame goes out
  cqfs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_ptr_q),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(rd_ptr_q),
    .rdata_o(rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign sum_step = STEP_W'(DATA_STEP0) + STEP_W'(rd_entry.len);

  // Select the data byte for the current frame step
  always_comb begin
    data_byte = 8'h00;
    for (int b = 0; b < MAX_CMD_BYTES; b++) begin
      if (step_q == STEP_W'(DATA_STEP0 + b)) begin
        data_byte = rd_entry.data[b];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (rd_en) begin
          state_d = S_FRAME;
        end
      end
      S_FRAME: begin
        if (step_q == sum_step) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Queue update and result generation
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    occ_d    = occ_q;
    step_d   = step_q;
    sum_d    = sum_q;
    valid_d  = 1'b0;
    status_d = ST_ACCEPTED;
    byte_d   = 8'h00;
    last_d   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          last_d  = 1'b1;
          if (kind_i == KIND_ENQ) begin
            if (!len_ok) begin
              status_d = ST_BAD_LEN;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_ACCEPTED;
              occ_d    = occ_q + 1'b1;
              wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
            end
          end else begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              // First sync byte needs no entry data
              status_d = ST_FRAME;
              byte_d   = SYNC_BYTE;
              last_d   = 1'b0;
              occ_d    = occ_q - 1'b1;
              rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
              step_d   = STEP_W'(1);
              sum_d    = 8'h00;
            end
          end
        end
      end
      S_FRAME: begin
        valid_d  = 1'b1;
        status_d = ST_FRAME;
        step_d   = step_q + 1'b1;
        if (step_q == sum_step) begin
          byte_d = sum_q;
          last_d = 1'b1;
        end else if (step_q < STEP_W'(SYNC_COUNT)) begin
          byte_d = SYNC_BYTE;
        end else if (step_q == STEP_W'(LEN_STEP)) begin
          byte_d = 8'(rd_entry.len);
        end else begin
          byte_d = data_byte;
          sum_d  = (sum_q + data_byte) & BYTE_MASK;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
    depth_d = DEPTH_W'(occ_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      step_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
      step_q   <= step_d;
      valid_q  <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    status_q <= status_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    depth_q  <= depth_d;
  end

  assign busy_o         = (state_q == S_FRAME);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign frame_byte_o   = byte_q;
  assign last_o         = last_q;
  assign depth_o        = depth_q;

  // Occupancy never exceeds the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // A send of a queued command starts a frame with busy held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (result_valid_o && busy_o && (status_o == ST_FRAME) && !last_o))
    else $error("frame did not start after send");

  // Results other than the last of an item only come from the framer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (busy_o && (status_o == ST_FRAME)))
    else $error("non-final result outside a frame");

  // While framing, a result comes out every cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> result_valid_o)
    else $error("gap in frame output");

  // The queue does not change while a frame goes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |-> ($stable(occ_q) && $stable(wr_ptr_q) && $stable(rd_ptr_q)))
    else $error("queue changed during frame");

endmodule
